// ===== rtl/aabb_triangle_overlap_test_assert.svh =====
// ----------------------------------------------------------------------------
// aabb_triangle_overlap_test_assert
// assertion macros shared by the triangle / box overlap test
// ----------------------------------------------------------------------------
// the including module provides i_clk and i_rst_n
`ifndef AABB_TRIANGLE_OVERLAP_TEST_ASSERT_SVH
`define AABB_TRIANGLE_OVERLAP_TEST_ASSERT_SVH

// condition holds at every edge outside reset
`define ATOT_ASSERT_IMPL(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define ATOT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/atot_pkg.sv =====
// ----------------------------------------------------------------------------
// atot_pkg
// widths, codes and stage payload types of the triangle / box overlap test
// ----------------------------------------------------------------------------
`default_nettype none

package atot_pkg;

    localparam int COORD_BITS = 24;
    localparam int EXT_BITS   = COORD_BITS - 1;
    localparam int TOL_BITS   = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = (COORD_BITS > TOL_BITS) ? COORD_BITS : TOL_BITS;

    // box-relative vertex and edge width
    localparam int VW  = COORD_BITS + 1;
    // coordinate product
    localparam int MW  = 2 * VW;
    // extent times edge magnitude
    localparam int RW  = EXT_BITS + VW;
    // normal component
    localparam int NW  = MW + 1;
    localparam int NLO = NW / 2;
    localparam int NHI = NW - NLO;
    // edge / face compare width
    localparam int BW  = ((RW > TOL_BITS) ? RW : TOL_BITS) + 2;
    localparam int ECW = ((MW + 1 > BW) ? MW + 1 : BW) + 1;
    // normal axis widths
    localparam int PCW = VW + NW + 1;
    localparam int RCW = EXT_BITS + NW;
    localparam int NBW = ((RCW > TOL_BITS) ? RCW : TOL_BITS) + 3;
    localparam int NCW = ((PCW + 2 > NBW) ? PCW + 2 : NBW) + 2;

    localparam int NUM_STAGES = 6;
    // a flag for each edge axis, each box face and the normal
    localparam int NUM_FLAGS  = 13;

    localparam logic [EXT_BITS-1:0] EXT_RESET = EXT_BITS'(128);

    localparam logic [3:0] AXIS_NONE   = 4'd0;
    localparam logic [3:0] AXIS_NORMAL = 4'd13;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CTR_X = 3'd0,
        CFG_CTR_Y = 3'd1,
        CFG_CTR_Z = 3'd2,
        CFG_EXT_X = 3'd3,
        CFG_EXT_Y = 3'd4,
        CFG_EXT_Z = 3'd5,
        CFG_TOL   = 3'd6
    } t_cfg_idx;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [EXT_BITS-1:0]          t_ext;
    typedef logic [TOL_BITS-1:0]          t_tol;
    typedef logic signed [VW-1:0]         t_val;
    typedef logic [VW-1:0]                t_mag;
    typedef logic signed [MW-1:0]         t_mul;
    typedef logic [RW-1:0]                t_rad;
    typedef logic signed [NW-1:0]         t_nrm;

    typedef struct packed {
        t_coord vert0_x;
        t_coord vert0_y;
        t_coord vert0_z;
        t_coord vert1_x;
        t_coord vert1_y;
        t_coord vert1_z;
        t_coord vert2_x;
        t_coord vert2_y;
        t_coord vert2_z;
    } t_in_beat;

    typedef struct packed {
        logic       overlaps;
        logic [3:0] separating_axis;
    } t_out_beat;

    typedef struct packed {
        t_coord [2:0] ctr;
        t_ext   [2:0] ext;
        t_tol         tol;
    } t_cfg;

    // box-relative vertices, edges and edge magnitudes
    typedef struct packed {
        t_val [2:0][2:0] v;
        t_val [2:0][2:0] f;
        t_mag [2:0][2:0] fa;
    } t_s1;

    // projection, radius and normal products; index [box axis][edge][vertex pick]
    typedef struct packed {
        t_mul [2:0][2:0][1:0] m1;
        t_mul [2:0][2:0][1:0] m2;
        t_rad [2:0][2:0]      r1;
        t_rad [2:0][2:0]      r2;
        t_mul [2:0]           na;
        t_mul [2:0]           nb;
        t_val [2:0][2:0]      v;
    } t_s2;

    // edge and face verdicts, normal and first vertex
    typedef struct packed {
        logic [NUM_FLAGS-2:0] sep;
        t_nrm [2:0]           n;
        t_val [2:0]           v0;
    } t_s3;

    function automatic int nxt3(input int k);
        return (k == 2) ? 0 : k + 1;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/atot_prep.sv =====
// ----------------------------------------------------------------------------
// atot_prep
// stage 1: vertices relative to the box center, edges and edge magnitudes
// ----------------------------------------------------------------------------
`default_nettype none

module atot_prep
    import atot_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_en,
    input  wire t_in_beat i_beat,
    input  wire t_cfg     i_cfg,
    output t_s1           o_s1
);

    t_s1 r_s1;
    t_s1 n_s1;

    always_comb begin
        t_coord w_t [3][3];
        t_val   w_f;
        w_t[0][0] = i_beat.vert0_x;
        w_t[0][1] = i_beat.vert0_y;
        w_t[0][2] = i_beat.vert0_z;
        w_t[1][0] = i_beat.vert1_x;
        w_t[1][1] = i_beat.vert1_y;
        w_t[1][2] = i_beat.vert1_z;
        w_t[2][0] = i_beat.vert2_x;
        w_t[2][1] = i_beat.vert2_y;
        w_t[2][2] = i_beat.vert2_z;
        n_s1 = r_s1;
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                n_s1.v[k][j] = VW'($signed(w_t[k][j])) - VW'($signed(i_cfg.ctr[j]));
                w_f = VW'($signed(w_t[nxt3(k)][j])) - VW'($signed(w_t[k][j]));
                n_s1.f[k][j] = w_f;
                n_s1.fa[k][j] = w_f[VW-1] ? VW'(~w_f + VW'(1)) : VW'(w_f);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

`default_nettype wire

// ===== rtl/atot_mul.sv =====
// ----------------------------------------------------------------------------
// atot_mul
// stage 2: projection, radius and normal products
// ----------------------------------------------------------------------------
`default_nettype none

module atot_mul
    import atot_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_en,
    input  wire t_s1  i_s1,
    input  wire t_cfg i_cfg,
    output t_s2       o_s2
);

    t_s2 r_s2;
    t_s2 n_s2;

    always_comb begin
        int u;
        int w;
        int kv;
        n_s2 = r_s2;
        for (int i = 0; i < 3; i++) begin
            u = nxt3(i);
            w = nxt3(u);
            for (int j = 0; j < 3; j++) begin
                // both ends of the edge project alike, so take v[j] and v[j+2]
                for (int s = 0; s < 2; s++) begin
                    kv = (s == 0) ? j : nxt3(nxt3(j));
                    n_s2.m1[i][j][s] = $signed(i_s1.v[kv][w]) * $signed(i_s1.f[j][u]);
                    n_s2.m2[i][j][s] = $signed(i_s1.v[kv][u]) * $signed(i_s1.f[j][w]);
                end
                n_s2.r1[i][j] = i_cfg.ext[u] * i_s1.fa[j][w];
                n_s2.r2[i][j] = i_cfg.ext[w] * i_s1.fa[j][u];
            end
        end
        for (int c = 0; c < 3; c++) begin
            u = nxt3(c);
            w = nxt3(u);
            n_s2.na[c] = $signed(i_s1.f[0][u]) * $signed(i_s1.f[1][w]);
            n_s2.nb[c] = $signed(i_s1.f[0][w]) * $signed(i_s1.f[1][u]);
        end
        n_s2.v = i_s1.v;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;

endmodule

`default_nettype wire

// ===== rtl/atot_axis.sv =====
// ----------------------------------------------------------------------------
// atot_axis
// stage 3: edge and face axis verdicts, triangle normal
// ----------------------------------------------------------------------------
`default_nettype none

module atot_axis
    import atot_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_en,
    input  wire t_s2  i_s2,
    input  wire t_cfg i_cfg,
    output t_s3       o_s3
);

    t_s3 r_s3;
    t_s3 n_s3;

    always_comb begin
        logic signed [ECW-1:0] w_pa;
        logic signed [ECW-1:0] w_pb;
        logic signed [ECW-1:0] w_p2;
        logic signed [ECW-1:0] w_lo;
        logic signed [ECW-1:0] w_hi;
        logic signed [ECW-1:0] w_bnd;
        n_s3 = r_s3;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                w_pa = ECW'($signed(i_s2.m1[i][j][0])) - ECW'($signed(i_s2.m2[i][j][0]));
                w_pb = ECW'($signed(i_s2.m1[i][j][1])) - ECW'($signed(i_s2.m2[i][j][1]));
                w_lo = (w_pa < w_pb) ? w_pa : w_pb;
                w_hi = (w_pa < w_pb) ? w_pb : w_pa;
                w_bnd = ECW'(i_s2.r1[i][j]) + ECW'(i_s2.r2[i][j]) + ECW'(i_cfg.tol);
                n_s3.sep[3 * i + j] = (-w_hi > w_bnd) || (w_lo > w_bnd);
            end
        end
        // face axes: plain interval test on each coordinate
        for (int i = 0; i < 3; i++) begin
            w_pa = ECW'($signed(i_s2.v[0][i]));
            w_pb = ECW'($signed(i_s2.v[1][i]));
            w_p2 = ECW'($signed(i_s2.v[2][i]));
            w_lo = (w_pa < w_pb) ? w_pa : w_pb;
            w_lo = (w_p2 < w_lo) ? w_p2 : w_lo;
            w_hi = (w_pa < w_pb) ? w_pb : w_pa;
            w_hi = (w_p2 > w_hi) ? w_p2 : w_hi;
            w_bnd = ECW'(i_cfg.ext[i]) + ECW'(i_cfg.tol);
            n_s3.sep[9 + i] = (-w_hi > w_bnd) || (w_lo > w_bnd);
        end
        for (int c = 0; c < 3; c++) begin
            n_s3.n[c] = NW'($signed(i_s2.na[c])) - NW'($signed(i_s2.nb[c]));
        end
        n_s3.v0 = i_s2.v[0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3 <= n_s3;
        end
    end

    assign o_s3 = r_s3;

endmodule

`default_nettype wire

// ===== rtl/atot_nrm.sv =====
// ----------------------------------------------------------------------------
// atot_nrm
// stages 4 and 5: normal axis projection and radius in split products
// ----------------------------------------------------------------------------
`default_nettype none

module atot_nrm
    import atot_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_en_a,
    input  wire logic i_en_b,
    input  wire t_s3  i_s3,
    input  wire t_cfg i_cfg,
    output logic      o_sep
);

    logic signed [VW+NHI-1:0]   r_pph [3];
    logic signed [VW+NLO:0]     r_ppl [3];
    logic [EXT_BITS+NHI-1:0]    r_rrh [3];
    logic [EXT_BITS+NLO-1:0]    r_rrl [3];
    logic signed [VW+NHI-1:0]   n_pph [3];
    logic signed [VW+NLO:0]     n_ppl [3];
    logic [EXT_BITS+NHI-1:0]    n_rrh [3];
    logic [EXT_BITS+NLO-1:0]    n_rrl [3];
    logic signed [PCW-1:0]      r_p [3];
    logic [RCW-1:0]             r_r [3];
    logic signed [PCW-1:0]      n_p [3];
    logic [RCW-1:0]             n_r [3];

    // split products: high half signed, low half unsigned
    always_comb begin
        logic [NW-1:0] w_abs;
        for (int c = 0; c < 3; c++) begin
            w_abs = i_s3.n[c][NW-1] ? NW'(~i_s3.n[c] + NW'(1)) : NW'(i_s3.n[c]);
            n_pph[c] = $signed(i_s3.v0[c]) * $signed(i_s3.n[c][NW-1:NLO]);
            n_ppl[c] = $signed(i_s3.v0[c]) * $signed({1'b0, i_s3.n[c][NLO-1:0]});
            n_rrh[c] = i_cfg.ext[c] * w_abs[NW-1:NLO];
            n_rrl[c] = i_cfg.ext[c] * w_abs[NLO-1:0];
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_p[c] = PCW'($signed({r_pph[c], {NLO{1'b0}}})) + PCW'(r_ppl[c]);
            n_r[c] = RCW'({r_rrh[c], {NLO{1'b0}}}) + RCW'(r_rrl[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_a) begin
            r_pph <= n_pph;
            r_ppl <= n_ppl;
            r_rrh <= n_rrh;
            r_rrl <= n_rrl;
        end
        if (i_en_b) begin
            r_p <= n_p;
            r_r <= n_r;
        end
    end

    // all vertices share one projection on the normal
    always_comb begin
        logic signed [NCW-1:0] w_p;
        logic signed [NCW-1:0] w_bnd;
        w_p = NCW'(r_p[0]) + NCW'(r_p[1]) + NCW'(r_p[2]);
        w_bnd = NCW'(r_r[0]) + NCW'(r_r[1]) + NCW'(r_r[2]) + NCW'(i_cfg.tol);
        o_sep = (w_p > w_bnd) || (-w_p > w_bnd);
    end

endmodule

`default_nettype wire

// ===== rtl/aabb_triangle_overlap_test.sv =====
// ----------------------------------------------------------------------------
// aabb_triangle_overlap_test
// separating axis test of one triangle against a configured box per beat
// ----------------------------------------------------------------------------
//  channel   signals                              beat
//  cfg       i_cfg_we i_cfg_idx i_cfg_data         one register write
//  in        i_in_valid o_in_ready i_in_beat       one triangle
//  out       o_out_valid i_out_ready o_out_beat    overlap flag and axis code
//
//  one triangle per cycle while the receiver takes results; an accepted
//  triangle passes these stages to o_out_beat: offsets and edges, products,
//  edge and face verdicts with the normal, normal split products, normal sums, result register
//  each stage has its own valid bit and loads when it is empty or the next
//  one moves, so stalls close bubbles and drop or repeat nothing
//  reset clears the valid bits and loads the register reset values
// ----------------------------------------------------------------------------
`default_nettype none

`include "aabb_triangle_overlap_test_assert.svh"

module aabb_triangle_overlap_test
    import atot_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire t_in_beat                 i_in_beat,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output t_out_beat                     o_out_beat
);

    t_cfg                   r_cfg;
    t_cfg                   n_cfg;
    logic [NUM_STAGES-1:0]  r_vld;
    logic [NUM_STAGES-1:0]  n_vld;
    logic [NUM_STAGES-1:0]  w_en;
    logic [NUM_FLAGS-2:0]   r_sep4;
    logic [NUM_FLAGS-2:0]   r_sep5;
    t_out_beat              r_out;
    t_out_beat              n_out;
    t_s1                    w_s1;
    t_s2                    w_s2;
    t_s3                    w_s3;
    logic                   w_nsep;

    // configuration writes, unknown indexes dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_CTR_X: begin
                    n_cfg.ctr[0] = i_cfg_data[COORD_BITS-1:0];
                end
                CFG_CTR_Y: begin
                    n_cfg.ctr[1] = i_cfg_data[COORD_BITS-1:0];
                end
                CFG_CTR_Z: begin
                    n_cfg.ctr[2] = i_cfg_data[COORD_BITS-1:0];
                end
                CFG_EXT_X: begin
                    n_cfg.ext[0] = i_cfg_data[EXT_BITS-1:0];
                end
                CFG_EXT_Y: begin
                    n_cfg.ext[1] = i_cfg_data[EXT_BITS-1:0];
                end
                CFG_EXT_Z: begin
                    n_cfg.ext[2] = i_cfg_data[EXT_BITS-1:0];
                end
                CFG_TOL: begin
                    n_cfg.tol = i_cfg_data[TOL_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // stage enables ripple back from the output register
    always_comb begin
        w_en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
        n_vld[0] = w_en[0] ? i_in_valid : r_vld[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            n_vld[k] = w_en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_cfg.ctr   <= '0;
            r_cfg.ext   <= {3{EXT_RESET}};
            r_cfg.tol   <= '0;
        end else begin
            r_vld <= n_vld;
            r_cfg <= n_cfg;
        end
    end

    atot_prep u_prep (
        .i_clk  (i_clk),
        .i_en   (w_en[0]),
        .i_beat (i_in_beat),
        .i_cfg  (r_cfg),
        .o_s1   (w_s1)
    );

    atot_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_en[1]),
        .i_s1   (w_s1),
        .i_cfg  (r_cfg),
        .o_s2   (w_s2)
    );

    atot_axis u_axis (
        .i_clk  (i_clk),
        .i_en   (w_en[2]),
        .i_s2   (w_s2),
        .i_cfg  (r_cfg),
        .o_s3   (w_s3)
    );

    atot_nrm u_nrm (
        .i_clk  (i_clk),
        .i_en_a (w_en[3]),
        .i_en_b (w_en[4]),
        .i_s3   (w_s3),
        .i_cfg  (r_cfg),
        .o_sep  (w_nsep)
    );

    // edge and face verdicts wait for the normal
    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_sep4 <= w_s3.sep;
        end
        if (w_en[4]) begin
            r_sep5 <= r_sep4;
        end
        if (w_en[5]) begin
            r_out <= n_out;
        end
    end

    // first separating axis in test order wins; flag k maps to code k+1
    always_comb begin
        logic [NUM_FLAGS-1:0] w_flags;
        w_flags = {w_nsep, r_sep5};
        n_out.separating_axis = AXIS_NONE;
        for (int k = NUM_FLAGS - 1; k >= 0; k--) begin
            if (w_flags[k]) begin
                n_out.separating_axis = 4'(k + 1);
            end
        end
        n_out.overlaps = (n_out.separating_axis == AXIS_NONE);
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_vld[NUM_STAGES-1];
    assign o_out_beat  = r_out;

    `ATOT_ASSERT_IMPL(a_ovl_code, !o_out_valid || (o_out_beat.overlaps == (o_out_beat.separating_axis == AXIS_NONE)), "overlap flag disagrees with axis code")
    `ATOT_ASSERT_IMPL(a_axis_range, !o_out_valid || (o_out_beat.separating_axis <= AXIS_NORMAL), "axis code out of range")
    `ATOT_ASSERT_IMPL(a_full_stall, o_in_ready || (&r_vld), "input held off with a free stage")
    `ATOT_ASSERT_NEXT(a_enter, i_in_valid && o_in_ready, r_vld[0], "accepted beat missing from first stage")

endmodule

`default_nettype wire

// ===== test/atot_overlap_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// atot_overlap_checker
// watches the config, in and out channels of the triangle / box overlap test,
// works out the expected verdict of every triangle beat and compares
// ----------------------------------------------------------------------------
`default_nettype none

module atot_overlap_checker
    import atot_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  wire logic                     i_in_valid,
    input  wire logic                     i_in_ready,
    input  wire t_in_beat                 i_in_beat,
    input  wire logic                     i_out_valid,
    input  wire logic                     i_out_ready,
    input  wire t_out_beat                i_out_beat,
    output int                            o_errors,
    output int                            o_pending
);

    typedef logic signed [127:0] t_w;

    // box registers as the block should hold them
    t_coord box_ctr [0:2];
    t_ext   box_ext [0:2];
    t_tol   box_tol;

    // box-relative vertices of the triangle being predicted, [vertex*3 + coord]
    t_w rel_v [0:8];

    t_out_beat verdict_q [$];

    function automatic t_w mag(t_w x);
        return (x < 0) ? -x : x;
    endfunction

    // true when axis (a0,a1,a2) separates rel_v from the box
    function automatic bit axis_splits(t_w a0, t_w a1, t_w a2);
        t_w p, lo, hi, rad, far;
        lo = 0;
        hi = 0;
        for (int k = 0; k < 3; k++) begin
            p = rel_v[3*k] * a0 + rel_v[3*k+1] * a1 + rel_v[3*k+2] * a2;
            if (k == 0 || p < lo) lo = p;
            if (k == 0 || p > hi) hi = p;
        end
        rad = t_w'(box_ext[0]) * mag(a0) + t_w'(box_ext[1]) * mag(a1)
            + t_w'(box_ext[2]) * mag(a2);
        far = (-hi > lo) ? -hi : lo;
        return far > rad + t_w'(box_tol);
    endfunction

    function automatic t_out_beat overlap_verdict(t_in_beat b);
        t_w        abs_v [0:8];
        t_w        edg [0:8];
        t_w        n0, n1, n2;
        int        axis;
        t_out_beat r;
        abs_v[0] = b.vert0_x; abs_v[1] = b.vert0_y; abs_v[2] = b.vert0_z;
        abs_v[3] = b.vert1_x; abs_v[4] = b.vert1_y; abs_v[5] = b.vert1_z;
        abs_v[6] = b.vert2_x; abs_v[7] = b.vert2_y; abs_v[8] = b.vert2_z;
        for (int k = 0; k < 3; k++)
            for (int j = 0; j < 3; j++) begin
                rel_v[3*k+j] = abs_v[3*k+j] - t_w'(box_ctr[j]);
                edg[3*k+j]   = abs_v[3*((k+1)%3)+j] - abs_v[3*k+j];
            end
        axis = 0;
        // box axis crossed with each edge
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                if (axis == 0) begin
                    if (i == 0) begin
                        if (axis_splits(0, -edg[3*j+2], edg[3*j+1])) axis = 1 + j;
                    end else if (i == 1) begin
                        if (axis_splits(edg[3*j+2], 0, -edg[3*j])) axis = 4 + j;
                    end else begin
                        if (axis_splits(-edg[3*j+1], edg[3*j], 0)) axis = 7 + j;
                    end
                end
        // box faces
        if (axis == 0 && axis_splits(1, 0, 0)) axis = 10;
        if (axis == 0 && axis_splits(0, 1, 0)) axis = 11;
        if (axis == 0 && axis_splits(0, 0, 1)) axis = 12;
        // triangle normal
        if (axis == 0) begin
            n0 = edg[1] * edg[5] - edg[2] * edg[4];
            n1 = edg[2] * edg[3] - edg[0] * edg[5];
            n2 = edg[0] * edg[4] - edg[1] * edg[3];
            if (axis_splits(n0, n1, n2)) axis = AXIS_NORMAL;
        end
        r.overlaps        = (axis == 0);
        r.separating_axis = 4'(axis);
        return r;
    endfunction

    task automatic report(string what);
        $display("%0t checker: %s", $realtime, what);
        o_errors++;
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            box_ctr[0] = '0; box_ctr[1] = '0; box_ctr[2] = '0;
            box_ext[0] = EXT_RESET; box_ext[1] = EXT_RESET; box_ext[2] = EXT_RESET;
            box_tol    = '0;
            verdict_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_CTR_X: box_ctr[0] = t_coord'(i_cfg_data);
                    CFG_CTR_Y: box_ctr[1] = t_coord'(i_cfg_data);
                    CFG_CTR_Z: box_ctr[2] = t_coord'(i_cfg_data);
                    CFG_EXT_X: box_ext[0] = t_ext'(i_cfg_data);
                    CFG_EXT_Y: box_ext[1] = t_ext'(i_cfg_data);
                    CFG_EXT_Z: box_ext[2] = t_ext'(i_cfg_data);
                    CFG_TOL:   box_tol    = t_tol'(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (verdict_q.size() == 0) begin
                    report("result beat with nothing expected");
                end else begin
                    want = verdict_q.pop_front();
                    if (i_out_beat.overlaps !== want.overlaps)
                        report($sformatf("overlaps %0b, expected %0b",
                                         i_out_beat.overlaps, want.overlaps));
                    if (i_out_beat.separating_axis !== want.separating_axis)
                        report($sformatf("separating_axis %0d, expected %0d",
                                         i_out_beat.separating_axis,
                                         want.separating_axis));
                end
            end
            if (i_in_valid && i_in_ready)
                verdict_q.push_back(overlap_verdict(i_in_beat));
        end
        o_pending = verdict_q.size();
    end

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the triangle / box overlap test
// ----------------------------------------------------------------------------
// runs several box settings (reset values, offset box with slack, extreme
// centers with empty extents, huge box with full slack, random box); each
// starts with idle register writes, then triangle beats in bursts while the
// receiver stalls on its own pattern; the checker predicts every verdict
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import atot_pkg::*;

    // depth of the pipeline; wait a little longer at the end
    localparam int PIPE_DEPTH  = 6;
    localparam int DRAIN_WAIT  = PIPE_DEPTH + 4;
    // longest correct quiet stretch is a sender gap or a receiver stall
    localparam int QUIET_LIMIT = 5000;
    localparam int RAND_BEATS  = 250;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;
    logic                     i_in_valid;
    logic                     o_in_ready;
    t_in_beat                 i_in_beat;
    logic                     o_out_valid;
    logic                     i_out_ready;
    t_out_beat                o_out_beat;

    int errors;
    int pending;

    // box center and extents as last written, so random triangles can land near the box
    int box_ctr [0:2];
    int box_ext [0:2];

    aabb_triangle_overlap_test dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

    atot_overlap_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_beat  (o_out_beat),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // receiver: ready probability is redrawn on a free-running counter, full speed included
    int ready_pct = 100;
    int ready_cnt = 0;
    always @(posedge i_clk) begin
        ready_cnt <= ready_cnt + 1;
        if (ready_cnt % 64 == 63) begin
            case ($urandom_range(0, 3))
                0: ready_pct <= 100;
                1: ready_pct <= 75;
                2: ready_pct <= 40;
                default: ready_pct <= 10;
            endcase
        end
        i_out_ready <= ($urandom_range(0, 99) < ready_pct);
    end

    // watchdog: cycles with no beat moving on any channel
    int quiet = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we
            || !i_rst_n) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("%0t watchdog: no beat moved for %0d cycles", $realtime, quiet);
            $display("** aabb_triangle_overlap_test: FAILED **");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic t_in_beat make_tri(int x0, int y0, int z0, int x1, int y1,
                                          int z1, int x2, int y2, int z2);
        t_in_beat b;
        b.vert0_x = t_coord'(x0); b.vert0_y = t_coord'(y0); b.vert0_z = t_coord'(z0);
        b.vert1_x = t_coord'(x1); b.vert1_y = t_coord'(y1); b.vert1_z = t_coord'(z1);
        b.vert2_x = t_coord'(x2); b.vert2_y = t_coord'(y2); b.vert2_z = t_coord'(z2);
        return b;
    endfunction

    // signed value spread over the given number of bits
    function automatic int spread(int nbits);
        return int'($urandom_range(0, (1 << nbits) - 1)) - (1 << (nbits - 1));
    endfunction

    // mostly a triangle around a point near the box, sometimes pure noise
    function automatic t_in_beat random_tri();
        t_in_beat     b;
        logic [223:0] noise;
        int           c [0:8];
        int           base [0:2];
        int           reach, tri_bits;
        if ($urandom_range(0, 3) == 0) begin
            noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            b = noise[$bits(t_in_beat)-1:0];
        end else begin
            reach    = $urandom_range(2, 16);
            tri_bits = $urandom_range(1, reach);
            for (int j = 0; j < 3; j++)
                base[j] = box_ctr[j] + spread(reach) + (box_ext[j] >>> $urandom_range(0, 8));
            for (int k = 0; k < 9; k++)
                c[k] = base[k % 3] + spread(tri_bits);
            // a repeated vertex now and then gives a zero edge
            if ($urandom_range(0, 15) == 0) begin
                c[3] = c[0]; c[4] = c[1]; c[5] = c[2];
            end
            b = make_tri(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8]);
        end
        return b;
    endfunction

    // one beat; called right after an edge, returns at the accepting edge
    task automatic send_tri(t_in_beat b);
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // all seven registers, only while the block is empty
    task automatic write_box(int cx, int cy, int cz, int ex, int ey, int ez, int tol);
        int vals [0:6];
        vals = '{cx, cy, cz, ex, ey, ez, tol};
        for (int i = 0; i <= int'(CFG_TOL); i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_BITS'(i);
            i_cfg_data <= CFG_DATA_BITS'(vals[i]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        box_ctr = '{cx, cy, cz};
        box_ext = '{ex & 32'h7f_ffff, ey & 32'h7f_ffff, ez & 32'h7f_ffff};
    endtask

    task automatic random_phase();
        int burst;
        int sent;
        sent = 0;
        while (sent < RAND_BEATS) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && sent < RAND_BEATS; k++) begin
                send_tri(random_tri());
                sent++;
            end
            // hold off once per phase until everything is back
            if (sent >= RAND_BEATS / 2 && sent - burst < RAND_BEATS / 2) begin
                wait_drained();
            end else if ($urandom_range(0, 2) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    localparam int CMAX = 8388607;
    localparam int CMIN = -8388608;

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_in_beat   = '0;
        i_out_ready = 1'b0;
        box_ctr     = '{0, 0, 0};
        box_ext     = '{128, 128, 128};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed beats against the reset box (center 0, half size 128)
        send_tri(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));              // degenerate, inside
        send_tri(make_tri(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
        send_tri(make_tri(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
        send_tri(make_tri(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN));
        send_tri(make_tri(CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX));
        send_tri(make_tri(-50, -50, 0, 50, -50, 0, 0, 60, 10));     // inside the box
        send_tri(make_tri(500, 0, 0, 600, 10, 0, 550, 0, 40));      // beyond +x face
        send_tri(make_tri(-500, 0, 0, -600, 10, 0, -550, 0, 40));   // beyond -x face
        send_tri(make_tri(0, 500, 0, 10, 600, 0, 0, 550, 40));      // beyond +y face
        send_tri(make_tri(0, -500, 0, 10, -600, 0, 0, -550, 40));   // beyond -y face
        send_tri(make_tri(0, 0, 500, 10, 0, 600, 40, 0, 550));      // beyond +z face
        send_tri(make_tri(0, 0, -500, 10, 0, -600, 40, 0, -550));   // beyond -z face
        send_tri(make_tri(600, 0, 0, 0, 600, 0, 0, 0, 600));        // plane past a corner
        send_tri(make_tri(200, 200, -300, 200, 200, 300, 400, 0, 0)); // sliver near an edge
        send_tri(make_tri(300, -300, 0, 300, -300, 0, 900, 0, 20)); // zero edge
        send_tri(make_tri(128, 0, 0, 128, 50, 0, 128, 0, 50));      // touching the face
        send_tri(make_tri(129, 0, 0, 129, 50, 0, 129, 0, 50));      // just off the face
        send_tri(make_tri(-1000, -1000, 0, 1000, -1000, 0, 0, 1000, 0)); // big, cuts box
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        // reset values written back explicitly
        write_box(0, 0, 0, 128, 128, 128, 0);
        random_phase();

        // offset box with some slack
        write_box(1000, -2000, 500, 300, 800, 50, 100);
        send_tri(make_tri(1301, -2000, 500, 1301, -1900, 500, 1301, -2000, 540));
        send_tri(make_tri(1400, -2000, 500, 1400, -1900, 500, 1400, -2000, 540));
        random_phase();

        // extreme centers, empty extents
        write_box(CMAX, CMIN, 0, 0, 0, 0, 0);
        send_tri(make_tri(CMAX, CMIN, 0, CMAX, CMIN, 0, CMAX, CMIN, 0));
        send_tri(make_tri(CMIN, CMAX, 0, CMAX, CMIN, 1, CMIN, CMIN, CMAX));
        random_phase();

        // largest box, largest slack
        write_box(0, 0, 0, CMAX, CMAX, CMAX, 65535);
        send_tri(make_tri(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX));
        random_phase();

        // random box
        write_box(spread(16), spread(16), spread(16), $urandom_range(0, 4096),
                  $urandom_range(0, 4096), $urandom_range(0, 4096),
                  $urandom_range(0, 65535));
        random_phase();

        if (errors == 0) begin
            $display("** aabb_triangle_overlap_test: PASSED **");
        end else begin
            $display("** aabb_triangle_overlap_test: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/atot_pkg.sv
rtl/atot_prep.sv
rtl/atot_mul.sv
rtl/atot_axis.sv
rtl/atot_nrm.sv
rtl/aabb_triangle_overlap_test.sv
test/atot_overlap_checker.sv
test/tb_top.sv
